// ===== hw/rtl/i2c_master_transfer_sequencer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer assertion macros
// Property shorthands used by the checker attached to the top level.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH

// antecedent holds this cycle -> consequent holds the same cycle
`define I2CMTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds this cycle -> consequent holds the next cycle
`define I2CMTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/i2cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Types and codes shared by the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  localparam logic [2:0] CMD_LOAD     = 3'd0;
  localparam logic [2:0] CMD_START_WR = 3'd1;
  localparam logic [2:0] CMD_START_RD = 3'd2;
  localparam logic [2:0] CMD_STATUS   = 3'd3;
  localparam logic [2:0] CMD_TICK     = 3'd4;
  localparam logic [2:0] CMD_READ     = 3'd5;

  localparam logic [4:0] ST_BUS_ERROR  = 5'd0;
  localparam logic [4:0] ST_START      = 5'd1;
  localparam logic [4:0] ST_RESTART    = 5'd2;
  localparam logic [4:0] ST_SLA_W_ACK  = 5'd3;
  localparam logic [4:0] ST_SLA_W_NACK = 5'd4;
  localparam logic [4:0] ST_DAT_W_ACK  = 5'd5;
  localparam logic [4:0] ST_DAT_W_NACK = 5'd6;
  localparam logic [4:0] ST_ARB_LOST   = 5'd7;
  localparam logic [4:0] ST_SLA_R_ACK  = 5'd8;
  localparam logic [4:0] ST_SLA_R_NACK = 5'd9;
  localparam logic [4:0] ST_DAT_R_ACK  = 5'd10;
  localparam logic [4:0] ST_DAT_R_NACK = 5'd11;

  localparam logic [1:0] OC_PENDING = 2'd0;
  localparam logic [1:0] OC_SUCCESS = 2'd1;
  localparam logic [1:0] OC_ERROR   = 2'd2;

  localparam logic [7:0] TIMEOUT_RST = 8'd5;
  localparam logic [7:0] TICKS_MAX   = 8'hff;

  typedef struct packed {
    logic [2:0] command;
    logic [6:0] slave_address;
    logic [4:0] byte_count;
    logic       stop_at_end;
    logic [4:0] status_code;
    logic       idx_ok;
  } item_t;

  typedef struct packed {
    logic [7:0] addr_byte;
    logic [4:0] remaining;
    logic       stop_when_done;
    logic [1:0] outcome;
    logic [7:0] elapsed;
  } st_t;

  typedef struct packed {
    logic       we;
    logic       wr_at_ptr;
    logic       rd_at_ptr;
    logic       ptr_step;
    logic       ptr_zero;
  } mem_ctl_t;

  typedef struct packed {
    logic       tx_load;
    logic       tx_from_buf;
    logic [7:0] tx_byte;
    logic       set_start;
    logic       set_stop;
    logic       set_ack;
    logic       clear_start;
    logic       clear_ack;
    logic       clear_irq;
    logic       reset_ctl;
    logic       buf_rd;
  } act_t;

  typedef struct packed {
    logic       tx_load;
    logic [7:0] tx_byte;
    logic       set_start;
    logic       set_stop;
    logic       set_ack;
    logic       clear_start;
    logic       clear_ack;
    logic       clear_irq;
    logic       reset_controller;
    logic [1:0] outcome;
    logic       busy_res;
    logic [7:0] buffer_data;
  } res_t;

endpackage

// ===== hw/rtl/i2cmts_in_if.sv =====
// ----------------------------------------------------------------------------
// i2cmts_in_if
// Command channel: valid/ready handshake plus one command transaction.
// ----------------------------------------------------------------------------
interface i2cmts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [6:0] slave_address;
  logic [4:0] byte_count;
  logic       stop_at_end;
  logic [4:0] status_code;
  logic [7:0] bus_byte;
  logic [3:0] buffer_index;
  logic [7:0] buffer_value;

  modport source (
    output valid, command, slave_address, byte_count, stop_at_end,
    output status_code, bus_byte, buffer_index, buffer_value,
    input  ready
  );

  modport sink (
    input  valid, command, slave_address, byte_count, stop_at_end,
    input  status_code, bus_byte, buffer_index, buffer_value,
    output ready
  );
endinterface

// ===== hw/rtl/i2cmts_out_if.sv =====
// ----------------------------------------------------------------------------
// i2cmts_out_if
// Result channel: valid/ready handshake plus controller action transaction.
// ----------------------------------------------------------------------------
interface i2cmts_out_if;
  logic       valid;
  logic       ready;
  logic       tx_load;
  logic [7:0] tx_byte;
  logic       set_start;
  logic       set_stop;
  logic       set_ack;
  logic       clear_start;
  logic       clear_ack;
  logic       clear_irq;
  logic       reset_controller;
  logic [1:0] outcome;
  logic       busy_res;
  logic [7:0] buffer_data;

  modport source (
    output valid, tx_load, tx_byte, set_start, set_stop, set_ack,
    output clear_start, clear_ack, clear_irq, reset_controller,
    output outcome, busy_res, buffer_data,
    input  ready
  );

  modport sink (
    input  valid, tx_load, tx_byte, set_start, set_stop, set_ack,
    input  clear_start, clear_ack, clear_irq, reset_controller,
    input  outcome, busy_res, buffer_data,
    output ready
  );
endinterface

// ===== hw/rtl/i2cmts_decode.sv =====
// ----------------------------------------------------------------------------
// i2cmts_decode
// Command and controller status decode: next transfer state, buffer
// access control and controller flag actions for one command.
// ----------------------------------------------------------------------------
module i2cmts_decode (
  input  i2cmts_pkg::item_t    item,
  input  i2cmts_pkg::st_t      st,
  input  logic [7:0]           timeout_ms,
  output i2cmts_pkg::st_t      st_nxt,
  output i2cmts_pkg::mem_ctl_t mc,
  output i2cmts_pkg::act_t     act
);
  import i2cmts_pkg::*;

  logic [4:0] rem_dec;
  logic [7:0] ticks_inc;

  assign rem_dec   = (st.remaining != 5'd0) ? st.remaining - 5'd1 : 5'd0;
  assign ticks_inc = (st.elapsed < TICKS_MAX) ? st.elapsed + 8'd1 : st.elapsed;

  always_comb begin
    st_nxt = st;
    mc     = '0;
    act    = '0;
    case (item.command)
      CMD_LOAD: begin
        mc.we = item.idx_ok;
      end
      CMD_START_WR, CMD_START_RD: begin
        st_nxt.outcome   = OC_PENDING;
        st_nxt.remaining = item.byte_count;
        st_nxt.elapsed   = 8'd0;
        st_nxt.addr_byte = {item.slave_address, item.command == CMD_START_RD};
        if (item.command == CMD_START_WR) begin
          st_nxt.stop_when_done = item.stop_at_end;
        end
        mc.ptr_zero   = 1'b1;
        act.set_start = 1'b1;
      end
      CMD_STATUS: begin
        act.clear_irq = 1'b1;
        case (item.status_code)
          ST_BUS_ERROR, ST_SLA_W_NACK, ST_DAT_W_NACK, ST_SLA_R_NACK: begin
            act.set_stop   = 1'b1;
            act.set_ack    = 1'b1;
            st_nxt.outcome = OC_ERROR;
          end
          ST_START, ST_RESTART: begin
            act.clear_start = 1'b1;
            act.tx_load     = 1'b1;
            act.tx_byte     = st.addr_byte;
          end
          ST_SLA_W_ACK: begin
            act.tx_load      = 1'b1;
            act.tx_from_buf  = 1'b1;
            mc.rd_at_ptr     = 1'b1;
            mc.ptr_step      = 1'b1;
            st_nxt.remaining = rem_dec;
          end
          ST_DAT_W_ACK: begin
            if (st.remaining == 5'd0) begin
              st_nxt.outcome = OC_SUCCESS;
              act.set_stop   = st.stop_when_done;
            end else begin
              act.tx_load      = 1'b1;
              act.tx_from_buf  = 1'b1;
              mc.rd_at_ptr     = 1'b1;
              mc.ptr_step      = 1'b1;
              st_nxt.remaining = rem_dec;
            end
          end
          ST_ARB_LOST: begin
            act.set_ack    = 1'b1;
            act.set_start  = 1'b1;
            st_nxt.outcome = OC_ERROR;
          end
          ST_SLA_R_ACK: begin
            act.set_ack = 1'b1;
          end
          ST_DAT_R_ACK: begin
            mc.we            = 1'b1;
            mc.wr_at_ptr     = 1'b1;
            mc.ptr_step      = 1'b1;
            st_nxt.remaining = rem_dec;
            act.clear_ack    = (rem_dec == 5'd0);
            act.set_ack      = (rem_dec != 5'd0);
          end
          ST_DAT_R_NACK: begin
            act.set_stop   = 1'b1;
            act.set_ack    = 1'b1;
            st_nxt.outcome = OC_SUCCESS;
          end
          default: begin
          end
        endcase
      end
      CMD_TICK: begin
        if (st.outcome == OC_PENDING) begin
          st_nxt.elapsed = ticks_inc;
          if (ticks_inc >= timeout_ms) begin
            act.reset_ctl  = 1'b1;
            st_nxt.outcome = OC_ERROR;
          end
        end
      end
      CMD_READ: begin
        act.buf_rd = item.idx_ok;
      end
      default: begin
      end
    endcase
  end
endmodule

// ===== hw/rtl/i2c_master_transfer_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_unit
// I2C master transfer sequencer with transfer buffer and timeout.
// ----------------------------------------------------------------------------
// Accepts one command transaction per clock while input ready is high, and
// returns exactly one result transaction per command, in order. A result
// passes from the buffer-read stage, which holds the synchronous read of the
// transfer buffer, into the output register. Transfer state is updated at the
// accepting edge, so commands stream back to back; input ready drops only
// while the output register and the buffer-read stage are both full and the
// result is not taken. Buffer entries read before they are written return
// arbitrary data. timeout_ms may be written through cfg_we/cfg_wdata while
// no command is in flight.
module i2c_master_transfer_sequencer_unit #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  i2cmts_in_if.sink           in_ch,
  i2cmts_out_if.source        out_ch
);
  import i2cmts_pkg::*;

  localparam int PW   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int IDXW = (PW > 4) ? PW : 4;
  localparam logic [PW-1:0] PTR_LAST = PW'(BUFFER_DEPTH - 1);

  logic [7:0]    timeout_r;
  st_t           st_r;
  st_t           st_nxt;
  logic [PW-1:0] ptr_r;
  logic [PW-1:0] ptr_nxt;

  item_t         item;
  mem_ctl_t      mc;
  act_t          act;

  logic [IDXW-1:0] idx_wide;
  logic [PW-1:0]   idx_addr;
  logic [PW-1:0]   rd_addr;
  logic [PW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic [7:0]      buf_mem [BUFFER_DEPTH];
  logic [7:0]      rd_data_r;

  logic        s1_valid_r;
  act_t        s1_act_r;
  logic [1:0]  s1_outcome_r;
  logic        s1_busy_r;
  logic        s1_move;
  res_t        s1_res;

  logic        out_valid_r;
  res_t        out_res_r;

  logic        accept;

  assign s1_move     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign accept      = in_ch.valid && in_ch.ready;

  assign idx_wide = IDXW'(in_ch.buffer_index);
  assign idx_addr = idx_wide[PW-1:0];

  always_comb begin
    item.command       = in_ch.command;
    item.slave_address = in_ch.slave_address;
    item.byte_count    = in_ch.byte_count;
    item.stop_at_end   = in_ch.stop_at_end;
    item.status_code   = in_ch.status_code;
    item.idx_ok        = ({28'd0, in_ch.buffer_index} < 32'(BUFFER_DEPTH));
  end

  i2cmts_decode u_decode (
    .item       (item),
    .st         (st_r),
    .timeout_ms (timeout_r),
    .st_nxt     (st_nxt),
    .mc         (mc),
    .act        (act)
  );

  always_comb begin
    ptr_nxt = ptr_r;
    if (mc.ptr_zero) begin
      ptr_nxt = '0;
    end else if (mc.ptr_step) begin
      ptr_nxt = (ptr_r == PTR_LAST) ? '0 : ptr_r + PW'(1);
    end
  end

  assign rd_addr = mc.rd_at_ptr ? ptr_r : idx_addr;
  assign wr_addr = mc.wr_at_ptr ? ptr_r : idx_addr;
  assign wr_data = mc.wr_at_ptr ? in_ch.bus_byte : in_ch.buffer_value;

  // transfer buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && mc.we) begin
      buf_mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data_r <= buf_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '{addr_byte: 8'd0, remaining: 5'd0, stop_when_done: 1'b0,
                 outcome: OC_SUCCESS, elapsed: 8'd0};
      ptr_r <= '0;
    end else if (accept) begin
      st_r  <= st_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act_r     <= act;
      s1_outcome_r <= st_nxt.outcome;
      s1_busy_r    <= (st_nxt.remaining != 5'd0);
    end
  end

  always_comb begin
    s1_res.tx_load          = s1_act_r.tx_load;
    s1_res.tx_byte          = s1_act_r.tx_from_buf ? rd_data_r : s1_act_r.tx_byte;
    s1_res.set_start        = s1_act_r.set_start;
    s1_res.set_stop         = s1_act_r.set_stop;
    s1_res.set_ack          = s1_act_r.set_ack;
    s1_res.clear_start      = s1_act_r.clear_start;
    s1_res.clear_ack        = s1_act_r.clear_ack;
    s1_res.clear_irq        = s1_act_r.clear_irq;
    s1_res.reset_controller = s1_act_r.reset_ctl;
    s1_res.outcome          = s1_outcome_r;
    s1_res.busy_res         = s1_busy_r;
    s1_res.buffer_data      = s1_act_r.buf_rd ? rd_data_r : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r <= s1_res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.tx_load          = out_res_r.tx_load;
  assign out_ch.tx_byte          = out_res_r.tx_byte;
  assign out_ch.set_start        = out_res_r.set_start;
  assign out_ch.set_stop         = out_res_r.set_stop;
  assign out_ch.set_ack          = out_res_r.set_ack;
  assign out_ch.clear_start      = out_res_r.clear_start;
  assign out_ch.clear_ack        = out_res_r.clear_ack;
  assign out_ch.clear_irq        = out_res_r.clear_irq;
  assign out_ch.reset_controller = out_res_r.reset_controller;
  assign out_ch.outcome          = out_res_r.outcome;
  assign out_ch.busy_res         = out_res_r.busy_res;
  assign out_ch.buffer_data      = out_res_r.buffer_data;
endmodule

// ===== hw/rtl/i2cmts_checker.sv =====
// ----------------------------------------------------------------------------
// i2cmts_checker
// Port-level checks on the sequencer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_transfer_sequencer_unit_assert.svh"

module i2cmts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       tx_load,
  input logic [7:0] tx_byte,
  input logic       clear_irq,
  input logic       reset_controller,
  input logic [1:0] outcome
);
  import i2cmts_pkg::*;

  `I2CMTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `I2CMTS_ASSERT_NOW(a_abort_err, clk, rst_n, out_valid && reset_controller, outcome == OC_ERROR, "timeout abort without error outcome")
  `I2CMTS_ASSERT_NOW(a_tx_zero, clk, rst_n, out_valid && !tx_load, tx_byte == 8'h00, "tx byte set without load")
  `I2CMTS_ASSERT_NOW(a_irq_tick, clk, rst_n, out_valid && clear_irq, !reset_controller, "status event and timeout in one transaction")
endmodule

bind i2c_master_transfer_sequencer_unit i2cmts_checker u_i2cmts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .tx_load          (out_ch.tx_load),
  .tx_byte          (out_ch.tx_byte),
  .clear_irq        (out_ch.clear_irq),
  .reset_controller (out_ch.reset_controller),
  .outcome          (out_ch.outcome)
);

// ===== test/tb_i2c_master_transfer_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_master_transfer_sequencer_unit
// Self-checking bench for the I2C master transfer sequencer. A short directed
// table covers reset state, error status codes, unused commands and a full
// write and read transfer. Random write/read transfers, tick bursts and noise
// follow, under several timeout settings. Each accepted command is run
// through a local model of the sequencer, and every result transaction is
// compared field by field against the oldest expected action set.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmts_pkg::*;

  localparam int BUF_DEPTH   = 16;
  localparam int PHASE_ITEMS = 90;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 4;

  typedef struct packed {
    logic [2:0] command;
    logic [6:0] slave_address;
    logic [4:0] byte_count;
    logic       stop_at_end;
    logic [4:0] status_code;
    logic [7:0] bus_byte;
    logic [3:0] buffer_index;
    logic [7:0] buffer_value;
  } cmd_t;

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t r;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  i2cmts_in_if  in_ch();
  i2cmts_out_if out_ch();

  i2c_master_transfer_sequencer_unit #(
    .BUFFER_DEPTH(BUF_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // sequencer model state
  logic [7:0] sq_buf    [BUF_DEPTH];
  bit         sq_buf_ok [BUF_DEPTH];
  logic [7:0] sq_addr;
  logic [4:0] sq_remaining;
  logic [3:0] sq_ptr;
  logic       sq_stop;
  logic [1:0] sq_outcome;
  logic [7:0] sq_elapsed;
  logic [7:0] sq_timeout;

  res_t     pending_actions_q [$];
  dir_row_t dir_q [$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       cycle_count = 0;
  bit       no_idle = 1'b0;
  res_t     mon_want;
  res_t     mon_got;

  always #5 clk = ~clk;

  function automatic cmd_t mk_cmd(input logic [2:0] cmd, input logic [6:0] addr,
                                  input logic [4:0] cnt, input logic stop,
                                  input logic [4:0] st, input logic [7:0] rx,
                                  input logic [3:0] idx, input logic [7:0] val);
    cmd_t c;
    c = '{cmd, addr, cnt, stop, st, rx, idx, val};
    return c;
  endfunction

  function automatic res_t typed_res(input logic [1:0] oc, input logic ci, input logic sp,
                                     input logic sa, input logic [7:0] bd);
    res_t r;
    r = '0;
    r.outcome     = oc;
    r.clear_irq   = ci;
    r.set_stop    = sp;
    r.set_ack     = sa;
    r.buffer_data = bd;
    return r;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.command       = ($urandom_range(99) < 4) ? 3'($urandom_range(7, 6))
                                               : 3'($urandom_range(5));
    c.slave_address = 7'($urandom_range(127));
    c.byte_count    = 5'($urandom_range(16));
    c.stop_at_end   = 1'($urandom_range(1));
    c.status_code   = 5'($urandom_range(31));
    c.bus_byte      = 8'($urandom_range(255));
    c.buffer_index  = 4'($urandom_range(15));
    c.buffer_value  = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] take_tx_byte();
    logic [7:0] b;
    b = sq_buf[sq_ptr];
    if (sq_remaining != 0) sq_remaining = sq_remaining - 5'd1;
    sq_ptr = sq_ptr + 4'd1;
    return b;
  endfunction

  function automatic void store_rx_byte(input logic [7:0] b);
    sq_buf[sq_ptr]    = b;
    sq_buf_ok[sq_ptr] = 1'b1;
    if (sq_remaining != 0) sq_remaining = sq_remaining - 5'd1;
    sq_ptr = sq_ptr + 4'd1;
  endfunction

  function automatic res_t predict_actions(input cmd_t c);
    res_t r;
    r = '0;
    case (c.command)
      CMD_LOAD: begin
        sq_buf[c.buffer_index]    = c.buffer_value;
        sq_buf_ok[c.buffer_index] = 1'b1;
      end
      CMD_START_WR, CMD_START_RD: begin
        sq_outcome   = OC_PENDING;
        sq_remaining = c.byte_count;
        sq_ptr       = '0;
        sq_elapsed   = '0;
        sq_addr      = {c.slave_address, c.command == CMD_START_RD};
        if (c.command == CMD_START_WR) sq_stop = c.stop_at_end;
        r.set_start = 1'b1;
      end
      CMD_STATUS: begin
        r.clear_irq = 1'b1;
        case (c.status_code)
          ST_BUS_ERROR, ST_SLA_W_NACK, ST_DAT_W_NACK, ST_SLA_R_NACK: begin
            r.set_stop = 1'b1;
            r.set_ack  = 1'b1;
            sq_outcome = OC_ERROR;
          end
          ST_START, ST_RESTART: begin
            r.clear_start = 1'b1;
            r.tx_load     = 1'b1;
            r.tx_byte     = sq_addr;
          end
          ST_SLA_W_ACK: begin
            r.tx_load = 1'b1;
            r.tx_byte = take_tx_byte();
          end
          ST_DAT_W_ACK: begin
            if (sq_remaining == 0) begin
              sq_outcome = OC_SUCCESS;
              r.set_stop = sq_stop;
            end else begin
              r.tx_load = 1'b1;
              r.tx_byte = take_tx_byte();
            end
          end
          ST_ARB_LOST: begin
            r.set_ack   = 1'b1;
            r.set_start = 1'b1;
            sq_outcome  = OC_ERROR;
          end
          ST_SLA_R_ACK: r.set_ack = 1'b1;
          ST_DAT_R_ACK: begin
            store_rx_byte(c.bus_byte);
            if (sq_remaining == 0) r.clear_ack = 1'b1;
            else r.set_ack = 1'b1;
          end
          ST_DAT_R_NACK: begin
            r.set_stop = 1'b1;
            r.set_ack  = 1'b1;
            sq_outcome = OC_SUCCESS;
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (sq_outcome == OC_PENDING) begin
          if (sq_elapsed < TICKS_MAX) sq_elapsed = sq_elapsed + 8'd1;
          if (sq_elapsed >= sq_timeout) begin
            r.reset_controller = 1'b1;
            sq_outcome         = OC_ERROR;
          end
        end
      end
      CMD_READ: r.buffer_data = sq_buf[c.buffer_index];
      default: ;
    endcase
    r.outcome  = sq_outcome;
    r.busy_res = (sq_remaining != 0);
    return r;
  endfunction

  // buffer entries are only read once written
  function automatic bit needs_fill(input cmd_t c, output logic [3:0] slot);
    slot = c.buffer_index;
    if (c.command == CMD_READ) return !sq_buf_ok[c.buffer_index];
    slot = sq_ptr;
    if (c.command == CMD_STATUS &&
        (c.status_code == ST_SLA_W_ACK ||
         (c.status_code == ST_DAT_W_ACK && sq_remaining != 0)))
      return !sq_buf_ok[sq_ptr];
    return 1'b0;
  endfunction

  task automatic send_cmd(input cmd_t c, input bit typed, input res_t tres);
    res_t pred;
    while (!no_idle && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= c.command;
    in_ch.slave_address <= c.slave_address;
    in_ch.byte_count    <= c.byte_count;
    in_ch.stop_at_end   <= c.stop_at_end;
    in_ch.status_code   <= c.status_code;
    in_ch.bus_byte      <= c.bus_byte;
    in_ch.buffer_index  <= c.buffer_index;
    in_ch.buffer_value  <= c.buffer_value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred = predict_actions(c);
    pending_actions_q.push_back(typed ? tres : pred);
    n_sent++;
  endtask

  task automatic drive_cmd(input cmd_t c);
    cmd_t       fill;
    logic [3:0] slot;
    if (needs_fill(c, slot)) begin
      fill              = rand_cmd();
      fill.command      = CMD_LOAD;
      fill.buffer_index = slot;
      send_cmd(fill, 1'b0, '0);
    end
    send_cmd(c, 1'b0, '0);
  endtask

  task automatic drive_op(input logic [2:0] op);
    cmd_t c;
    c = rand_cmd();
    c.command = op;
    drive_cmd(c);
  endtask

  // status event with occasional tick, buffer read or corrupted code
  task automatic drive_status(input logic [4:0] code);
    cmd_t c;
    if ($urandom_range(99) < 8) drive_op(CMD_TICK);
    if ($urandom_range(99) < 4) drive_op(CMD_READ);
    c = rand_cmd();
    c.command     = CMD_STATUS;
    c.status_code = ($urandom_range(99) < 6) ? 5'($urandom_range(31)) : code;
    drive_cmd(c);
  endtask

  task automatic drive_start(input bit rd, input int n);
    cmd_t c;
    c = rand_cmd();
    c.command    = rd ? CMD_START_RD : CMD_START_WR;
    c.byte_count = 5'(n);
    drive_cmd(c);
  endtask

  task automatic run_transfer(input bit rd);
    int   n;
    cmd_t c;
    n = ($urandom_range(9) == 0) ? 16 : $urandom_range(4);
    if (!rd) begin
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(1) == 1) begin
          c = rand_cmd();
          c.command      = CMD_LOAD;
          c.buffer_index = 4'(k);
          drive_cmd(c);
        end
      end
    end
    drive_start(rd, n);
    drive_status(($urandom_range(3) == 0) ? ST_RESTART : ST_START);
    if (rd) begin
      drive_status(ST_SLA_R_ACK);
      for (int k = 0; k < n; k++) drive_status(ST_DAT_R_ACK);
      drive_status(ST_DAT_R_NACK);
    end else begin
      drive_status(ST_SLA_W_ACK);
      for (int k = 0; k < ((n == 0) ? 1 : n); k++) drive_status(ST_DAT_W_ACK);
    end
  endtask

  task automatic run_ticks(input int n);
    drive_start(1'($urandom_range(1)), $urandom_range(4));
    repeat (n) drive_op(CMD_TICK);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_actions_q.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sq_timeout = v;
    cfg_we    <= 1'b0;
  endtask

  task automatic cmp_field(input string name, input logic [7:0] e, input logic [7:0] a);
    if (a !== e) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      mon_got = '{out_ch.tx_load, out_ch.tx_byte, out_ch.set_start, out_ch.set_stop,
                  out_ch.set_ack, out_ch.clear_start, out_ch.clear_ack, out_ch.clear_irq,
                  out_ch.reset_controller, out_ch.outcome, out_ch.busy_res,
                  out_ch.buffer_data};
      if (pending_actions_q.size() == 0) begin
        n_errors++;
        $display("%0t ns: unexpected result transaction, expected none actual %h",
                 $time, mon_got);
      end else begin
        mon_want = pending_actions_q.pop_front();
        cmp_field("tx_load", 8'(mon_want.tx_load), 8'(mon_got.tx_load));
        cmp_field("tx_byte", mon_want.tx_byte, mon_got.tx_byte);
        cmp_field("set_start", 8'(mon_want.set_start), 8'(mon_got.set_start));
        cmp_field("set_stop", 8'(mon_want.set_stop), 8'(mon_got.set_stop));
        cmp_field("set_ack", 8'(mon_want.set_ack), 8'(mon_got.set_ack));
        cmp_field("clear_start", 8'(mon_want.clear_start), 8'(mon_got.clear_start));
        cmp_field("clear_ack", 8'(mon_want.clear_ack), 8'(mon_got.clear_ack));
        cmp_field("clear_irq", 8'(mon_want.clear_irq), 8'(mon_got.clear_irq));
        cmp_field("reset_controller", 8'(mon_want.reset_controller),
                  8'(mon_got.reset_controller));
        cmp_field("outcome", 8'(mon_want.outcome), 8'(mon_got.outcome));
        cmp_field("busy_res", 8'(mon_want.busy_res), 8'(mon_got.busy_res));
        cmp_field("buffer_data", mon_want.buffer_data, mon_got.buffer_data);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_i2c_master_transfer_sequencer_unit: FAIL");
    $finish;
  end

  initial begin
    logic [7:0] plan [5];
    int         phase_end;
    int         pick;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.command       = '0;
    in_ch.slave_address = '0;
    in_ch.byte_count    = '0;
    in_ch.stop_at_end   = 1'b0;
    in_ch.status_code   = '0;
    in_ch.bus_byte      = '0;
    in_ch.buffer_index  = '0;
    in_ch.buffer_value  = '0;

    for (int i = 0; i < BUF_DEPTH; i++) begin
      sq_buf[i]    = '0;
      sq_buf_ok[i] = 1'b0;
    end
    sq_addr      = '0;
    sq_remaining = '0;
    sq_ptr       = '0;
    sq_stop      = 1'b0;
    sq_outcome   = OC_SUCCESS;
    sq_elapsed   = '0;
    sq_timeout   = TIMEOUT_RST;

    // idle state, unused commands, error status codes
    dir_q.push_back('{mk_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                      typed_res(OC_SUCCESS, 0, 0, 0, 8'h00)});
    dir_q.push_back('{mk_cmd(3'd6, 7'h7f, 5'd16, 1, 5'h1f, 8'hff, 4'hf, 8'hff), 1'b1,
                      typed_res(OC_SUCCESS, 0, 0, 0, 8'h00)});
    dir_q.push_back('{mk_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                      typed_res(OC_SUCCESS, 0, 0, 0, 8'h00)});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, 5'd31, 0, 0, 0), 1'b1,
                      typed_res(OC_SUCCESS, 1, 0, 0, 8'h00)});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_BUS_ERROR, 0, 0, 0), 1'b1,
                      typed_res(OC_ERROR, 1, 1, 1, 8'h00)});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_SLA_W_NACK, 0, 0, 0), 1'b1,
                      typed_res(OC_ERROR, 1, 1, 1, 8'h00)});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_SLA_R_NACK, 0, 0, 0), 1'b1,
                      typed_res(OC_ERROR, 1, 1, 1, 8'h00)});
    // buffer extremes
    dir_q.push_back('{mk_cmd(CMD_LOAD, 0, 0, 0, 0, 0, 4'd0, 8'h00), 1'b1,
                      typed_res(OC_ERROR, 0, 0, 0, 8'h00)});
    dir_q.push_back('{mk_cmd(CMD_LOAD, 0, 0, 0, 0, 0, 4'd15, 8'hff), 1'b1,
                      typed_res(OC_ERROR, 0, 0, 0, 8'h00)});
    dir_q.push_back('{mk_cmd(CMD_LOAD, 0, 0, 0, 0, 0, 4'd1, 8'ha5), 1'b1,
                      typed_res(OC_ERROR, 0, 0, 0, 8'h00)});
    dir_q.push_back('{mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 4'd15, 0), 1'b1,
                      typed_res(OC_ERROR, 0, 0, 0, 8'hff)});
    // two-byte write with stop
    dir_q.push_back('{mk_cmd(CMD_START_WR, 7'h7f, 5'd2, 1, 0, 0, 0, 0), 1'b0, '0});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_START, 0, 0, 0), 1'b0, '0});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_SLA_W_ACK, 0, 0, 0), 1'b0, '0});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_DAT_W_ACK, 0, 0, 0), 1'b0, '0});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_DAT_W_ACK, 0, 0, 0), 1'b0, '0});
    // one-byte read, stop flag kept from the write
    dir_q.push_back('{mk_cmd(CMD_START_RD, 7'h00, 5'd1, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_RESTART, 0, 0, 0), 1'b0, '0});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_SLA_R_ACK, 0, 0, 0), 1'b0, '0});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_DAT_R_ACK, 8'hff, 0, 0), 1'b0, '0});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_DAT_R_NACK, 0, 0, 0), 1'b0, '0});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_ARB_LOST, 0, 0, 0), 1'b0, '0});
    // zero-count write: byte still sent, count stays at zero
    dir_q.push_back('{mk_cmd(CMD_START_WR, 7'h55, 5'd0, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_SLA_W_ACK, 0, 0, 0), 1'b0, '0});
    dir_q.push_back('{mk_cmd(CMD_STATUS, 0, 0, 0, ST_DAT_W_ACK, 0, 0, 0), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_q[i]) send_cmd(dir_q[i].c, dir_q[i].typed, dir_q[i].r);

    plan[0] = 8'd1;
    plan[1] = 8'd255;
    plan[2] = 8'd0;
    plan[3] = 8'($urandom_range(254, 2));
    plan[4] = TIMEOUT_RST;

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain_results();
        write_timeout(plan[p-1]);
      end
      no_idle   = (p == 2);
      phase_end = n_sent + PHASE_ITEMS;
      if (p == 2) run_ticks(255);
      while (n_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 40) run_transfer(1'b0);
        else if (pick < 70) run_transfer(1'b1);
        else if (pick < 80) run_ticks($urandom_range(8, 1));
        else repeat ($urandom_range(4, 1)) drive_cmd(rand_cmd());
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_i2c_master_transfer_sequencer_unit: PASS");
    end else begin
      $display("tb_i2c_master_transfer_sequencer_unit: FAIL");
    end
    $finish;
  end

endmodule
